// ----- rtl/temperature_average_led_stepper_assert.svh -----
// Assertion macros for the temperature averaging stepper.
// Expects clk and rst_n in the scope of the file that includes it.
`ifndef TEMPERATURE_AVERAGE_LED_STEPPER_ASSERT_SVH
`define TEMPERATURE_AVERAGE_LED_STEPPER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TASL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TASL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- rtl/tasl_pkg.sv -----
// Shared widths, constants, codes and types for the temperature averaging stepper.
// No dependencies; compile first.
package tasl_pkg;

    localparam int ADC_W      = 12;
    localparam int TEMP_W     = 20;
    localparam int V25_W      = 12;
    localparam int THR_W      = 16;
    localparam int BASE_W     = 20;
    localparam int POS_W      = 2;
    localparam int STEP_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Code to Q8 degrees: ((adc*4801)>>6) - ((v25*1638)>>4) + 6400
    localparam int ADC_GAIN    = 4801;
    localparam int ADC_GAIN_W  = 13;
    localparam int ADC_SHIFT   = 6;
    localparam int V25_GAIN    = 1638;
    localparam int V25_GAIN_W  = 11;
    localparam int V25_SHIFT   = 4;
    localparam int TEMP_OFFSET = 6400;

    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_NONE     = 2'd0;
    localparam step_t STEP_UP       = 2'd1;
    localparam step_t STEP_DOWN     = 2'd2;
    localparam step_t STEP_RESERVED = 2'd3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_V25        = 2'd0;
    localparam cfg_idx_t REG_THRESHOLD  = 2'd1;
    localparam cfg_idx_t REG_START_BASE = 2'd2;

    typedef struct packed {
        logic [V25_W-1:0]         v25_mv;
        logic [THR_W-1:0]         threshold;
        logic signed [BASE_W-1:0] start_base;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        v25_mv:     V25_W'(760),
        threshold:  THR_W'(512),
        start_base: BASE_W'(0)
    };

    typedef struct packed {
        logic signed [TEMP_W-1:0] avg;
        logic [POS_W-1:0]         pos;
        step_t                    step;
    } result_t;

endpackage

// ----- rtl/tasl_if.sv -----
// Valid/ready channel interfaces for sensor words and result words.
// Depends on tasl_pkg.
interface tasl_sample_if;
    logic                       valid;
    logic                       ready;
    logic [tasl_pkg::ADC_W-1:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink (input valid, input adc_code, output ready);
endinterface

interface tasl_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [tasl_pkg::TEMP_W-1:0] average_temp_q8;
    logic [tasl_pkg::POS_W-1:0]         led_position;
    logic [tasl_pkg::STEP_W-1:0]        step_taken;

    modport source (output valid, output average_temp_q8, output led_position,
                    output step_taken, input ready);
    modport sink (input valid, input average_temp_q8, input led_position,
                  input step_taken, output ready);
endinterface

// ----- rtl/temperature_average_led_stepper.sv -----
// Top level of the temperature averaging ring-indicator stepper.
// Depends on tasl_pkg, tasl_if, tasl_convert, tasl_window, tasl_stepper.
//
// Takes one sensor word per cycle and returns one result word per cycle while
// result.ready does not hold the output back: the input register loads at
// acceptance, the conversion multiplies then fill the temperature register, and
// the window update with the base compare then fills the result register. The
// running sum and base are the only feedback, closed
// inside the last stage, so words flow back to back; each stage holds its word
// while the stage behind it is full, so the block keeps accepting until all
// three stages are occupied. The window is a WINDOW-entry memory with one write
// and one prefetch read per word; a fill flag makes unwritten slots count as
// zero, so no clearing pass follows reset. WINDOW must be a power of two.
// Write configuration only while no word is in flight.
module temperature_average_led_stepper #(
    parameter int WINDOW = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    tasl_sample_if.sink                         sample,
    tasl_result_if.source                       result,
    input  logic                                cfg_wen,
    input  logic [tasl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tasl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tasl_pkg::*;

    `include "temperature_average_led_stepper_assert.svh"

    cfg_t                     cfg_reg;
    cfg_t                     cfg_next;
    logic                     v1_reg;
    logic                     v1_next;
    logic                     v2_reg;
    logic                     v2_next;
    logic                     ov_reg;
    logic                     ov_next;
    logic                     ready1;
    logic                     ready2;
    logic                     ready3;
    logic                     accept;
    logic                     load_temp;
    logic                     en3;
    logic                     base_load;
    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W-1:0] avg;
    result_t                  res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                REG_V25:        cfg_next.v25_mv     = cfg_data[V25_W-1:0];
                REG_THRESHOLD:  cfg_next.threshold  = cfg_data[THR_W-1:0];
                REG_START_BASE: cfg_next.start_base = $signed(cfg_data[BASE_W-1:0]);
                default:        cfg_next = cfg_reg;
            endcase
        end
        base_load = cfg_wen && (cfg_index == REG_START_BASE);
    end

    // a stage takes a word when empty or when its word moves on
    always_comb
    begin
        ready3    = !ov_reg || result.ready;
        ready2    = !v2_reg || ready3;
        ready1    = !v1_reg || ready2;
        accept    = sample.valid && ready1;
        load_temp = v1_reg && ready2;
        en3       = v2_reg && ready3;
        v1_next   = accept || (v1_reg && !ready2);
        v2_next   = load_temp || (v2_reg && !ready3);
        ov_next   = en3 || (ov_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            v1_reg  <= v1_next;
            v2_reg  <= v2_next;
            ov_reg  <= ov_next;
        end
    end

    tasl_convert u_convert (
        .clk       (clk),
        .load_adc  (accept),
        .adc_code  (sample.adc_code),
        .load_temp (load_temp),
        .v25_mv    (cfg_reg.v25_mv),
        .temp      (temp)
    );

    tasl_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en3),
        .temp  (temp),
        .avg   (avg)
    );

    // base loads the written start value on the write edge itself
    tasl_stepper u_stepper (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en3),
        .avg       (avg),
        .cfg       (cfg_next),
        .base_load (base_load),
        .result    (res)
    );

    assign sample.ready           = ready1;
    assign result.valid           = ov_reg;
    assign result.average_temp_q8 = res.avg;
    assign result.led_position    = res.pos;
    assign result.step_taken      = res.step;

    `TASL_ASSERT_NEXT(a_result_loads, v2_reg && ready3, result.valid)
    `TASL_ASSERT_SAME(a_full_stall, v1_reg && v2_reg && ov_reg && !result.ready, !sample.ready)
    `TASL_ASSERT_SAME(a_step_code, result.valid, result.step_taken != STEP_RESERVED)

endmodule

// ----- rtl/tasl_convert.sv -----
// Input register and code-to-temperature conversion stage.
// Depends on tasl_pkg.
module tasl_convert (
    input  logic                               clk,
    input  logic                               load_adc,
    input  logic [tasl_pkg::ADC_W-1:0]         adc_code,
    input  logic                               load_temp,
    input  logic [tasl_pkg::V25_W-1:0]         v25_mv,
    output logic signed [tasl_pkg::TEMP_W-1:0] temp
);
    import tasl_pkg::*;

    localparam int PROD_A_W = ADC_W + ADC_GAIN_W;
    localparam int PROD_V_W = V25_W + V25_GAIN_W;
    localparam int PAD_A_W  = TEMP_W + 1 - (PROD_A_W - ADC_SHIFT);
    localparam int PAD_V_W  = TEMP_W + 1 - (PROD_V_W - V25_SHIFT);

    logic [ADC_W-1:0]         adc_reg;
    logic [PROD_A_W-1:0]      adc_prod;
    logic [PROD_V_W-1:0]      v25_prod;
    logic signed [TEMP_W:0]   temp_wide;
    logic signed [TEMP_W-1:0] temp_reg;

    always_comb
    begin
        adc_prod  = PROD_A_W'(adc_reg) * PROD_A_W'(ADC_GAIN);
        v25_prod  = PROD_V_W'(v25_mv) * PROD_V_W'(V25_GAIN);
        temp_wide = $signed({{PAD_A_W{1'b0}}, adc_prod[PROD_A_W-1:ADC_SHIFT]})
                  - $signed({{PAD_V_W{1'b0}}, v25_prod[PROD_V_W-1:V25_SHIFT]})
                  + (TEMP_W+1)'(TEMP_OFFSET);
    end

    always_ff @(posedge clk)
    begin
        if (load_adc)
        begin
            adc_reg <= adc_code;
        end
        // result always fits in 20 signed bits for any 12-bit inputs
        if (load_temp)
        begin
            temp_reg <= temp_wide[TEMP_W-1:0];
        end
    end

    assign temp = temp_reg;

endmodule

// ----- rtl/tasl_window.sv -----
// Ring of the last WINDOW temperatures, running sum and average.
// Depends on tasl_pkg.
module tasl_window #(
    parameter int WINDOW = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic signed [tasl_pkg::TEMP_W-1:0] temp,
    output logic signed [tasl_pkg::TEMP_W-1:0] avg
);
    import tasl_pkg::*;

    localparam int LOG2W = $clog2(WINDOW);
    localparam int SUM_W = TEMP_W + LOG2W;

    logic signed [TEMP_W-1:0] ring_mem [WINDOW];
    logic signed [TEMP_W-1:0] oldest_reg;
    logic signed [TEMP_W-1:0] oldest;
    logic [LOG2W-1:0]         slot_reg;
    logic [LOG2W-1:0]         slot_next;
    logic                     filled_reg;
    logic                     filled_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;

    always_comb
    begin
        slot_next   = slot_reg + LOG2W'(1);
        filled_next = filled_reg | (slot_reg == LOG2W'(WINDOW - 1));
        // slots not yet written since reset count as zero
        oldest      = filled_reg ? oldest_reg : '0;
        sum_next    = sum_reg - SUM_W'(oldest) + SUM_W'(temp);
        // floor division by WINDOW: drop the low bits of the exact sum
        avg         = $signed(sum_next[SUM_W-1:LOG2W]);
    end

    // write this slot, prefetch the one the next word will retire
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ring_mem[slot_reg] <= temp;
            oldest_reg         <= ring_mem[slot_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            filled_reg <= 1'b0;
            sum_reg    <= '0;
        end
        else if (en)
        begin
            slot_reg   <= slot_next;
            filled_reg <= filled_next;
            sum_reg    <= sum_next;
        end
    end

endmodule

// ----- rtl/tasl_stepper.sv -----
// Base compare, ring indicator position and result register.
// Depends on tasl_pkg.
module tasl_stepper (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic signed [tasl_pkg::TEMP_W-1:0] avg,
    input  tasl_pkg::cfg_t                     cfg,
    input  logic                               base_load,
    output tasl_pkg::result_t                  result
);
    import tasl_pkg::*;

    logic signed [BASE_W-1:0] base_reg;
    logic signed [BASE_W-1:0] base_next;
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_next;
    logic signed [TEMP_W:0]   diff_up;
    logic signed [TEMP_W:0]   diff_dn;
    logic signed [THR_W:0]    thr;
    step_t                    step;
    result_t                  result_reg;

    always_comb
    begin
        diff_up   = {avg[TEMP_W-1], avg} - {base_reg[BASE_W-1], base_reg};
        diff_dn   = {base_reg[BASE_W-1], base_reg} - {avg[TEMP_W-1], avg};
        thr       = $signed({1'b0, cfg.threshold});
        base_next = base_reg;
        pos_next  = pos_reg;
        step      = STEP_NONE;
        if (base_load)
        begin
            base_next = cfg.start_base;
        end
        else if (en)
        begin
            if (diff_up >= thr)
            begin
                pos_next  = pos_reg + POS_W'(1);
                base_next = avg;
                step      = STEP_UP;
            end
            else if (diff_dn >= thr)
            begin
                pos_next  = pos_reg - POS_W'(1);
                base_next = avg;
                step      = STEP_DOWN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= CFG_RESET.start_base;
            pos_reg  <= '0;
        end
        else
        begin
            base_reg <= base_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= '{avg: avg, pos: pos_next, step: step};
        end
    end

    assign result = result_reg;

endmodule

// ----- tb/sv/temperature_average_led_stepper_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for temperature_average_led_stepper: a directed table, then
// random sensor words under several register settings, checked against a local model.
// Depends on tasl_pkg, tasl_if and the RTL top level.
module temperature_average_led_stepper_test;
    import tasl_pkg::*;

    localparam int WINDOW        = 16;
    localparam int AVG_SHIFT     = $clog2(WINDOW);
    localparam int PHASE_WORDS   = 175;
    localparam int RANDOM_PHASES = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_CYCLES  = 60;

    // No register lives at this index; writes to it must be dropped.
    localparam cfg_idx_t REG_SPARE = 2'd3;

    typedef struct packed {
        logic                  is_write;
        cfg_idx_t              reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        logic [ADC_W-1:0]      code;
        logic                  typed;
        result_t               want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wen;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tasl_sample_if sample_ch ();
    tasl_result_if result_ch ();

    temperature_average_led_stepper #(
        .WINDOW(WINDOW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of the block's registers and state, at reset values.
    logic [V25_W-1:0] sensor_v25     = V25_W'(760);
    logic [THR_W-1:0] step_threshold = THR_W'(512);
    int               base_q8        = 0;
    logic [POS_W-1:0] led_at         = '0;
    int               window_temps [WINDOW] = '{default: 0};
    int               window_total   = 0;
    int               write_index    = 0;

    result_t awaited_results [$];
    int      mismatch_count = 0;
    int      send_idle_pct  = 0;
    int      recv_idle_pct  = 0;
    bit      stall_request  = 1'b0;

    function automatic result_t convert_and_average(input logic [ADC_W-1:0] code);
        int      temp;
        int      avg;
        result_t r;
        temp = ((int'(code) * ADC_GAIN) >>> ADC_SHIFT)
             - ((int'(sensor_v25) * V25_GAIN) >>> V25_SHIFT) + TEMP_OFFSET;
        window_total = window_total - window_temps[write_index] + temp;
        window_temps[write_index] = temp;
        write_index = (write_index + 1) % WINDOW;
        // Arithmetic shift floors negative sums.
        avg = window_total >>> AVG_SHIFT;
        r.step = STEP_NONE;
        if (avg - base_q8 >= int'(step_threshold)) begin
            led_at  = led_at + 2'd1;
            base_q8 = avg;
            r.step  = STEP_UP;
        end
        else if (base_q8 - avg >= int'(step_threshold)) begin
            led_at  = led_at - 2'd1;
            base_q8 = avg;
            r.step  = STEP_DOWN;
        end
        r.avg = TEMP_W'(avg);
        r.pos = led_at;
        return r;
    endfunction

    function automatic stim_row_t word_row(input logic [ADC_W-1:0] code);
        stim_row_t row;
        row      = '0;
        row.code = code;
        return row;
    endfunction

    function automatic stim_row_t write_row(input cfg_idx_t idx,
                                            input logic [CFG_DATA_W-1:0] value);
        stim_row_t row;
        row           = '0;
        row.is_write  = 1'b1;
        row.reg_index = idx;
        row.reg_value = value;
        return row;
    endfunction

    function automatic void set_idle_profile(input int word_no);
        if (word_no < 2 * PHASE_WORDS) begin
            send_idle_pct = 19;
            recv_idle_pct = 60;
        end
        else if (word_no < 4 * PHASE_WORDS) begin
            send_idle_pct = 60;
            recv_idle_pct = 19;
        end
        else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endfunction

    task automatic send_word(input logic [ADC_W-1:0] code, input logic typed,
                             input result_t want);
        result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid    <= 1'b1;
        sample_ch.adc_code <= code;
        do @(posedge clk); while (!sample_ch.ready);
        predicted = convert_and_average(code);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    // Drop valid and let every word in flight come out before touching registers.
    task automatic drain_pipeline();
        sample_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_V25:        sensor_v25 = value[V25_W-1:0];
            REG_THRESHOLD:  step_threshold = value[THR_W-1:0];
            REG_START_BASE: base_q8 = $signed(value[BASE_W-1:0]);
            default: ;
        endcase
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Result side: check each accepted word, then pick ready for the next edge.
    initial
    begin
        int      hold_left;
        result_t want;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with no expectation pending");
                    mismatch_count++;
                end
                else begin
                    want = awaited_results.pop_front();
                    if (result_ch.average_temp_q8 !== want.avg) begin
                        $error("average_temp_q8: expected %0d, got %0d",
                               want.avg, result_ch.average_temp_q8);
                        mismatch_count++;
                    end
                    if (result_ch.led_position !== want.pos) begin
                        $error("led_position: expected %0d, got %0d",
                               want.pos, result_ch.led_position);
                        mismatch_count++;
                    end
                    if (result_ch.step_taken !== want.step) begin
                        $error("step_taken: expected %0d, got %0d",
                               want.step, result_ch.step_taken);
                        mismatch_count++;
                    end
                end
            end
            if (stall_request) begin
                stall_request = 1'b0;
                hold_left     = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        stim_row_t             stim_table [$];
        logic [ADC_W-1:0]      code;
        logic [CFG_DATA_W-1:0] v25_word;
        logic [CFG_DATA_W-1:0] thr_word;
        logic [CFG_DATA_W-1:0] base_word;
        int                    walk_code;
        int                    pick;
        int                    word_no;

        rst_n              <= 1'b0;
        cfg_wen            <= 1'b0;
        cfg_index          <= REG_V25;
        cfg_data           <= '0;
        sample_ch.valid    <= 1'b0;
        sample_ch.adc_code <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stim_table = '{
            // First word after reset: code 0 sits far below base 0, so step down.
            '{is_write: 1'b0, reg_index: REG_V25, reg_value: '0, code: '0, typed: 1'b1,
              want: '{avg: -20'sd4463, pos: 2'd3, step: STEP_DOWN}},
            word_row(12'hFFF), word_row(12'hFFF), word_row(12'h000),
            // zero threshold: a step on every word, up when the average equals the base
            write_row(REG_THRESHOLD, 20'd0),
            word_row(12'h800), word_row(12'h7FF), word_row(12'h001), word_row(12'hFFE),
            // bits above the register width must be ignored
            write_row(REG_V25, 20'hFFFFF),
            word_row(12'h000), word_row(12'hFFF),
            write_row(REG_V25, 20'd0),
            write_row(REG_THRESHOLD, 20'hFFFFF),
            // base loads at once, at both ends of its range
            write_row(REG_START_BASE, 20'h7FFFF),
            word_row(12'hFFF), word_row(12'h555),
            write_row(REG_START_BASE, 20'h80000),
            word_row(12'h000), word_row(12'hAAA),
            write_row(REG_SPARE, 20'hFFFFF),
            word_row(12'h123),
            write_row(REG_THRESHOLD, 20'd512),
            write_row(REG_V25, 20'd760),
            write_row(REG_START_BASE, 20'd0)
        };

        set_idle_profile(0);
        foreach (stim_table[i]) begin
            if (stim_table[i].is_write) begin
                drain_pipeline();
                write_register(stim_table[i].reg_index, stim_table[i].reg_value);
            end
            else
                send_word(stim_table[i].code, stim_table[i].typed, stim_table[i].want);
        end

        walk_code = 2048;
        word_no   = 0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_pipeline();
            v25_word  = CFG_DATA_W'($urandom_range(0, 20'hFFFFF));
            thr_word  = CFG_DATA_W'($urandom_range(0, 2500))
                      | (CFG_DATA_W'($urandom_range(0, 15)) << THR_W);
            base_word = CFG_DATA_W'($urandom());
            case (phase)
                0: v25_word = 20'd760;
                1: begin
                    v25_word = '0;
                    thr_word = '0;
                end
                2: begin
                    v25_word  = 20'hFFF;
                    thr_word  = 20'hFFFF;
                    base_word = 20'h80000;
                end
                3: base_word = 20'h7FFFF;
                default: ;
            endcase
            write_register(REG_V25, v25_word);
            write_register(REG_THRESHOLD, thr_word);
            write_register(REG_START_BASE, base_word);
            if (phase == 4)
                write_register(REG_SPARE, CFG_DATA_W'($urandom()));

            for (int n = 0; n < PHASE_WORDS; n++) begin
                set_idle_profile(word_no);
                // Hold results off for a while so the pipeline backs up into the input.
                if (phase == RANDOM_PHASES - 1 && n == 30)
                    stall_request = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    // slow drift exercises gradual up and down stepping
                    walk_code = walk_code + $urandom_range(0, 96) - 48;
                    if (walk_code < 0)
                        walk_code = 0;
                    if (walk_code > 4095)
                        walk_code = 4095;
                    code = ADC_W'(walk_code);
                end
                else if (pick < 70)
                    code = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
                else
                    code = ADC_W'($urandom_range(0, 4095));
                send_word(code, 1'b0, '0);
                word_no++;
            end
        end

        drain_pipeline();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tasl_pkg.sv
rtl/tasl_if.sv
rtl/tasl_convert.sv
rtl/tasl_window.sv
rtl/tasl_stepper.sv
rtl/temperature_average_led_stepper.sv
tb/sv/temperature_average_led_stepper_test.sv
